FILE: hdl/ptd_pkg.sv
`timescale 1ns / 1ps
package ptd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [15:0] RANGE_MAX_MM = 16'd2000;
    localparam logic [15:0] RANGE_MIN_MM = 16'd30;
    localparam logic [7:0]  COUNT_CEIL   = 8'd255;

    localparam logic [2:0] REG_WEIGHT_PRESENT = 3'd0;
    localparam logic [2:0] REG_NEAR_LIMIT     = 3'd1;
    localparam logic [2:0] REG_DROP_LIMIT     = 3'd2;
    localparam logic [2:0] REG_FAR_LIMIT      = 3'd3;
    localparam logic [2:0] REG_SETTLE_TIME    = 3'd4;
    localparam logic [2:0] REG_HOLD_TIME      = 3'd5;
    localparam logic [2:0] REG_CONFIRM_COUNT  = 3'd6;

    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_ARRIVED    = 3'd1;
    localparam logic [2:0] CODE_MONITORING = 3'd2;
    localparam logic [2:0] CODE_ALERT      = 3'd3;
    localparam logic [2:0] CODE_COOLDOWN   = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_ARRIVED    = 5'b00010,
        PH_MONITORING = 5'b00100,
        PH_ALERT      = 5'b01000,
        PH_COOLDOWN   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic signed [24:0] weight_raw;
        logic               weight_ready;
        logic [15:0]        range_raw;
        logic               range_timeout;
        logic [31:0]        now_ms;
    } sample_t;

    typedef struct packed {
        logic [2:0] phase_out;
        logic       arrive_event;
        logic       theft_event;
    } result_t;

    typedef struct packed {
        logic [22:0] weight_present;
        logic [10:0] near_limit;
        logic [23:0] drop_limit;
        logic [10:0] far_limit;
        logic [31:0] settle_time;
        logic [31:0] hold_time;
        logic [7:0]  confirm_count;
    } cfg_t;

    typedef struct packed {
        logic signed [24:0] weight;
        logic               dvalid;
        logic               idle_present;
        logic               arrived_absent;
        logic               monitor_far;
        logic [31:0]        now_ms;
    } cls_t;

    function automatic logic [7:0] count_up(input logic [7:0] c);
        return (c < COUNT_CEIL) ? c + 8'd1 : c;
    endfunction

    function automatic logic [7:0] count_down(input logic [7:0] c);
        return (c != 8'd0) ? c - 8'd1 : c;
    endfunction

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] code;
        case (p)
            PH_IDLE:       code = CODE_IDLE;
            PH_ARRIVED:    code = CODE_ARRIVED;
            PH_MONITORING: code = CODE_MONITORING;
            PH_ALERT:      code = CODE_ALERT;
            PH_COOLDOWN:   code = CODE_COOLDOWN;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/ptd_regs.sv
`timescale 1ns / 1ps
module ptd_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptd_pkg::DATA_W-1:0]   pwdata,
    output logic [ptd_pkg::DATA_W-1:0]   prdata,
    output ptd_pkg::cfg_t                cfg
);

    ptd_pkg::cfg_t cfg_reg;
    ptd_pkg::cfg_t cfg_next;
    logic [2:0]    index;
    logic          wr_en;

    assign index = paddr[4:2];
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                ptd_pkg::REG_WEIGHT_PRESENT: cfg_next.weight_present = pwdata[22:0];
                ptd_pkg::REG_NEAR_LIMIT:     cfg_next.near_limit = pwdata[10:0];
                ptd_pkg::REG_DROP_LIMIT:     cfg_next.drop_limit = pwdata[23:0];
                ptd_pkg::REG_FAR_LIMIT:      cfg_next.far_limit = pwdata[10:0];
                ptd_pkg::REG_SETTLE_TIME:    cfg_next.settle_time = pwdata;
                ptd_pkg::REG_HOLD_TIME:      cfg_next.hold_time = pwdata;
                ptd_pkg::REG_CONFIRM_COUNT:  cfg_next.confirm_count = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_present <= 23'd20000;
            cfg_reg.near_limit     <= 11'd300;
            cfg_reg.drop_limit     <= 24'd10000;
            cfg_reg.far_limit      <= 11'd400;
            cfg_reg.settle_time    <= 32'd3000;
            cfg_reg.hold_time      <= 32'd10000;
            cfg_reg.confirm_count  <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (index)
            ptd_pkg::REG_WEIGHT_PRESENT: prdata = {9'd0, cfg_reg.weight_present};
            ptd_pkg::REG_NEAR_LIMIT:     prdata = {21'd0, cfg_reg.near_limit};
            ptd_pkg::REG_DROP_LIMIT:     prdata = {8'd0, cfg_reg.drop_limit};
            ptd_pkg::REG_FAR_LIMIT:      prdata = {21'd0, cfg_reg.far_limit};
            ptd_pkg::REG_SETTLE_TIME:    prdata = cfg_reg.settle_time;
            ptd_pkg::REG_HOLD_TIME:      prdata = cfg_reg.hold_time;
            ptd_pkg::REG_CONFIRM_COUNT:  prdata = {24'd0, cfg_reg.confirm_count};
            default:                     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ptd_front.sv
`timescale 1ns / 1ps
module ptd_front (
    input  ptd_pkg::sample_t sample,
    input  ptd_pkg::cfg_t    cfg,
    output ptd_pkg::cls_t    cls
);

    logic signed [24:0] weight;
    logic signed [25:0] weight_ext;
    logic signed [25:0] present_lim;
    logic signed [25:0] absent_lim;
    logic               dvalid;
    logic [15:0]        dpm_ext;
    logic [15:0]        dtm_ext;

    always_comb
    begin
        weight      = sample.weight_ready ? sample.weight_raw : 25'sd0;
        weight_ext  = {weight[24], weight};
        present_lim = $signed({3'b000, cfg.weight_present});
        absent_lim  = $signed({4'b0000, cfg.weight_present[22:1]});
        dpm_ext     = {5'd0, cfg.near_limit};
        dtm_ext     = {5'd0, cfg.far_limit};
        dvalid      = !sample.range_timeout
                      && (sample.range_raw <= ptd_pkg::RANGE_MAX_MM)
                      && (sample.range_raw >= ptd_pkg::RANGE_MIN_MM);

        cls.weight         = weight;
        cls.dvalid         = dvalid;
        cls.idle_present   = (weight_ext > present_lim) && dvalid
                             && (sample.range_raw < dpm_ext);
        cls.arrived_absent = (weight_ext < absent_lim)
                             || (dvalid && (sample.range_raw > dpm_ext));
        cls.monitor_far    = dvalid && (sample.range_raw > dtm_ext);
        cls.now_ms         = sample.now_ms;
    end

endmodule

FILE: hdl/ptd_queue.sv
`timescale 1ns / 1ps
module ptd_queue #(
    parameter int DEPTH = ptd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptd_pkg::cls_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ptd_pkg::cls_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptd_pkg::cls_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/ptd_back.sv
`timescale 1ns / 1ps
module ptd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ptd_pkg::cfg_t     cfg,
    input  logic              item_valid,
    input  ptd_pkg::cls_t     item,
    output logic              item_take,
    output logic              empty,
    input  logic              pop,
    output ptd_pkg::result_t  result
);

    ptd_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]        enter_time_reg, enter_time_next;
    logic signed [24:0] baseline_reg, baseline_next;
    logic [7:0]         present_count_reg, present_count_next;
    logic [7:0]         absent_count_reg, absent_count_next;
    logic [7:0]         theft_count_reg, theft_count_next;
    logic               out_valid_reg, out_valid_next;
    ptd_pkg::result_t   out_reg, out_next;

    logic [31:0]        elapsed;
    logic signed [25:0] drop;
    logic               theft_cond;
    logic [7:0]         cnt;
    logic               change;
    logic               arrive;
    logic               theft;
    ptd_pkg::phase_t    target;

    assign item_take = item_valid && (!out_valid_reg || pop);
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        elapsed    = item.now_ms - enter_time_reg;
        drop       = {baseline_reg[24], baseline_reg} - {item.weight[24], item.weight};
        theft_cond = (drop > $signed({2'b00, cfg.drop_limit})) && item.monitor_far;

        present_count_next = present_count_reg;
        absent_count_next  = absent_count_reg;
        theft_count_next   = theft_count_reg;
        baseline_next      = baseline_reg;
        phase_next         = phase_reg;
        enter_time_next    = enter_time_reg;
        out_valid_next     = out_valid_reg && !pop;
        out_next           = out_reg;
        change             = 1'b0;
        arrive             = 1'b0;
        theft              = 1'b0;
        target             = ptd_pkg::PH_IDLE;
        cnt                = 8'd0;

        if (item_take)
        begin
            case (phase_reg)
                ptd_pkg::PH_IDLE:
                begin
                    cnt = present_count_reg;
                    if (item.idle_present)
                    begin
                        cnt = ptd_pkg::count_up(present_count_reg);
                    end
                    else if (item.dvalid)
                    begin
                        cnt = ptd_pkg::count_down(present_count_reg);
                    end
                    present_count_next = cnt;
                    if (cnt >= cfg.confirm_count)
                    begin
                        change = 1'b1;
                        target = ptd_pkg::PH_ARRIVED;
                    end
                end
                ptd_pkg::PH_ARRIVED:
                begin
                    cnt = item.arrived_absent ? ptd_pkg::count_up(absent_count_reg)
                                              : ptd_pkg::count_down(absent_count_reg);
                    absent_count_next = cnt;
                    if (cnt >= cfg.confirm_count)
                    begin
                        change = 1'b1;
                        target = ptd_pkg::PH_IDLE;
                    end
                    else if (elapsed >= cfg.settle_time)
                    begin
                        baseline_next = item.weight;
                        arrive        = 1'b1;
                        change        = 1'b1;
                        target        = ptd_pkg::PH_MONITORING;
                    end
                end
                ptd_pkg::PH_MONITORING:
                begin
                    cnt = theft_count_reg;
                    if (theft_cond)
                    begin
                        cnt = ptd_pkg::count_up(theft_count_reg);
                    end
                    else if (item.dvalid)
                    begin
                        cnt = ptd_pkg::count_down(theft_count_reg);
                    end
                    theft_count_next = cnt;
                    if (cnt >= cfg.confirm_count)
                    begin
                        change = 1'b1;
                        target = ptd_pkg::PH_ALERT;
                    end
                end
                ptd_pkg::PH_ALERT:
                begin
                    theft  = 1'b1;
                    change = 1'b1;
                    target = ptd_pkg::PH_COOLDOWN;
                end
                ptd_pkg::PH_COOLDOWN:
                begin
                    if (elapsed >= cfg.hold_time)
                    begin
                        change = 1'b1;
                        target = ptd_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    change = 1'b1;
                    target = ptd_pkg::PH_IDLE;
                end
            endcase

            if (change)
            begin
                phase_next         = target;
                enter_time_next    = item.now_ms;
                present_count_next = 8'd0;
                absent_count_next  = 8'd0;
                theft_count_next   = 8'd0;
            end

            out_valid_next        = 1'b1;
            out_next.phase_out    = ptd_pkg::phase_code(phase_next);
            out_next.arrive_event = arrive;
            out_next.theft_event  = theft;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ptd_pkg::PH_IDLE;
            enter_time_reg    <= '0;
            baseline_reg      <= '0;
            present_count_reg <= '0;
            absent_count_reg  <= '0;
            theft_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            enter_time_reg    <= enter_time_next;
            baseline_reg      <= baseline_next;
            present_count_reg <= present_count_next;
            absent_count_reg  <= absent_count_next;
            theft_count_reg   <= theft_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

FILE: hdl/parcel_theft_detector_fsm_top.sv
`timescale 1ns / 1ps
// The detector takes one sensor sample per clock while the queue is not full, and returns
// exactly one result beat per sample, in order. A pushed sample is classified against the
// thresholds on the way into a short queue, and the phase machine takes it from the queue when
// the output register is empty or being popped; its result is held in the output register,
// which drives the result ports. The phase machine takes one sample per cycle while results
// are popped; the queue and the output register let either side stall without losing a beat.
// Write the registers only while no sample is in flight.
module parcel_theft_detector_fsm_top #(
    parameter int QUEUE_DEPTH = ptd_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  ptd_pkg::sample_t           sample,
    output logic                       empty,
    input  logic                       pop,
    output ptd_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptd_pkg::ADDR_W-1:0] paddr,
    input  logic [ptd_pkg::DATA_W-1:0] pwdata,
    output logic [ptd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    ptd_pkg::cfg_t cfg;
    ptd_pkg::cls_t cls_in;
    ptd_pkg::cls_t cls_out;
    logic          q_valid;
    logic          q_take;

    assign pready = 1'b1;

    ptd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ptd_front u_front (
        .sample (sample),
        .cfg    (cfg),
        .cls    (cls_in)
    );

    ptd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_in),
        .full    (full),
        .pop     (q_take),
        .valid   (q_valid),
        .rd_data (cls_out)
    );

    ptd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (q_valid),
        .item       (cls_out),
        .item_take  (q_take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

FILE: hdl/ptd_checker.sv
`timescale 1ns / 1ps
module ptd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input ptd_pkg::result_t result
);

    a_arrive_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.arrive_event) |-> (result.phase_out == ptd_pkg::CODE_MONITORING))
        else $error("Arrival beat does not report the monitoring phase.");

    a_theft_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.theft_event) |-> (result.phase_out == ptd_pkg::CODE_COOLDOWN))
        else $error("Theft beat does not report the cooldown phase.");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.phase_out <= ptd_pkg::CODE_COOLDOWN))
        else $error("Result beat carries an unused phase code.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("Waiting result beat changed or vanished.");

endmodule

bind parcel_theft_detector_fsm_top ptd_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
